// ===== sv/zotk_pkg.sv =====
package zotk_pkg;

	localparam int MAX_SOURCES = 64;
	localparam int IDX_W       = $clog2(MAX_SOURCES);
	localparam int CNT_W       = $clog2(MAX_SOURCES + 1);

	localparam int TAG_W   = 16;
	localparam int RATE_W  = 32;
	localparam int PCT_W   = 7;
	localparam int RANK_W  = 6;
	localparam int SUM_W   = RATE_W + IDX_W;
	localparam int ENTRY_W = TAG_W + RATE_W;

	localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(10);

	// k = (pct * n + 50) / 100, division done as multiply by ceil(2^19 / 100)
	localparam int T_W       = PCT_W + CNT_W + 1;
	localparam int K_ROUND   = 50;
	localparam int RECIP_W   = 13;
	localparam int RECIP     = 5243;
	localparam int DIV_SHIFT = 19;
	localparam int KP_W      = T_W + RECIP_W;
	localparam int KQ_W      = KP_W - DIV_SHIFT;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [TAG_W-1:0] tag;
		logic [RATE_W-1:0] rate;
	} wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SUM_W-1:0] sum;
		logic             ovf;
	} job_t;

	typedef struct packed {
		logic idle;
		logic done;
	} bst_t;

endpackage

// ===== sv/zotk_if.sv =====
interface zotk_in_if;
	logic                        valid;
	logic                        ready;
	logic [zotk_pkg::TAG_W-1:0]  source_tag;
	logic [zotk_pkg::RATE_W-1:0] rate;
	logic                        last_item;

	modport source (output valid, source_tag, rate, last_item, input ready);
	modport sink (input valid, source_tag, rate, last_item, output ready);
endinterface

interface zotk_out_if;
	logic                        valid;
	logic                        ready;
	logic [zotk_pkg::TAG_W-1:0]  anomalous_tag;
	logic [zotk_pkg::RANK_W-1:0] rank;
	logic                        capacity_exceeded;
	logic                        last_result;

	modport source (output valid, anomalous_tag, rank, capacity_exceeded, last_result,
		input ready);
	modport sink (input valid, anomalous_tag, rank, capacity_exceeded, last_result,
		output ready);
endinterface

interface zotk_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [zotk_pkg::PCT_W-1:0] contamination_percent;

	modport source (output valid, contamination_percent, input ready);
	modport sink (input valid, contamination_percent, output ready);
endinterface

// ===== sv/zotk_front.sv =====
module zotk_front (
	input  logic            clk,
	input  logic            arst_n,
	zotk_in_if.sink         items,
	input  logic            done,
	output zotk_pkg::wr_t   wr,
	output zotk_pkg::job_t  job,
	output logic            job_push,
	output logic            busy
);
	import zotk_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             ovf_q;
	logic             pend_q;
	logic             acc;
	logic             room;

	assign items.ready = !pend_q;
	assign acc  = items.valid && items.ready;
	assign room = (cnt_q < CNT_W'(MAX_SOURCES));

	always_comb begin
		wr.en   = acc && room;
		wr.addr = cnt_q[IDX_W-1:0];
		wr.tag  = items.source_tag;
		wr.rate = items.rate;
		job.n   = room ? cnt_q + CNT_W'(1) : cnt_q;
		job.sum = room ? sum_q + SUM_W'(items.rate) : sum_q;
		job.ovf = ovf_q || !room;
	end

	assign job_push = acc && items.last_item;
	assign busy     = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			ovf_q  <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (job_push) begin
				// set closed: clear totals, hold input until selection ends
				cnt_q  <= '0;
				sum_q  <= '0;
				ovf_q  <= 1'b0;
				pend_q <= 1'b1;
			end else if (acc) begin
				cnt_q <= job.n;
				sum_q <= job.sum;
				ovf_q <= job.ovf;
			end
			if (done) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/zotk_fifo.sv =====
module zotk_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  zotk_pkg::job_t push_data,
	input  logic           pop,
	output zotk_pkg::job_t head,
	output logic           empty,
	output logic           full
);
	import zotk_pkg::*;

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= !wp_q;
			end
			if (pop && !empty) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

// ===== sv/zotk_back.sv =====
module zotk_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  zotk_pkg::wr_t               wr,
	input  zotk_pkg::job_t              head,
	input  logic                        empty,
	output logic                        pop,
	input  logic [zotk_pkg::PCT_W-1:0]  pct,
	zotk_out_if.source                  results,
	output zotk_pkg::bst_t              st
);
	import zotk_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_KMUL = 3'd1;
	localparam logic [2:0] B_KDIV = 3'd2;
	localparam logic [2:0] B_SCAN = 3'd3;
	localparam logic [2:0] B_EMIT = 3'd4;

	logic [ENTRY_W-1:0] mem [MAX_SOURCES];

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   n_q;
	logic [SUM_W-1:0]   sum_q;
	logic               ovf_q;
	logic [T_W-1:0]     kx_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   r_q;
	logic [CNT_W-1:0]   idx_q;
	logic [MAX_SOURCES-1:0] taken_q;

	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [ENTRY_W-1:0] rd_s1;
	logic               vld_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [TAG_W-1:0]   tag_s2;
	logic [SUM_W-1:0]   prod_s2;

	logic               found_q;
	logic [SUM_W-1:0]   best_score_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [TAG_W-1:0]   best_tag_q;

	logic               ovld_q;
	logic [TAG_W-1:0]   otag_q;
	logic [RANK_W-1:0]  orank_q;
	logic               oovf_q;
	logic               olast_q;

	logic               issue;
	logic               pass_end;
	logic               emit;
	logic               is_last;
	logic [SUM_W-1:0]   score;
	logic               better;
	logic [KP_W-1:0]    kprod;
	logic [KQ_W-1:0]    kq;
	logic [CNT_W-1:0]   k_new;
	logic [CNT_W+RATE_W-1:0] prod_full;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.tag, wr.rate};
		end
		rd_s1 <= mem[idx_q[IDX_W-1:0]];
	end

	assign issue    = (state_q == B_SCAN) && (idx_q < n_q);
	assign pass_end = (state_q == B_SCAN) && !issue && !vld_s1 && !vld_s2;
	assign emit     = (state_q == B_EMIT) && (!ovld_q || results.ready);
	assign is_last  = (r_q + CNT_W'(1) == k_q);
	assign pop      = (state_q == B_IDLE) && !empty;

	assign prod_full = (CNT_W+RATE_W)'(n_q) * (CNT_W+RATE_W)'(rd_s1[RATE_W-1:0]);
	assign score     = (prod_s2 >= sum_q) ? prod_s2 - sum_q : sum_q - prod_s2;
	assign better    = vld_s2 && (!found_q || score > best_score_q);

	assign kprod = KP_W'(kx_q) * KP_W'(RECIP);
	assign kq    = kprod[KP_W-1:DIV_SHIFT];

	always_comb begin
		if (kq == '0) begin
			k_new = CNT_W'(1);
		end else if (kq > KQ_W'(n_q)) begin
			k_new = n_q;
		end else begin
			k_new = CNT_W'(kq);
		end
	end

	assign st.idle = (state_q == B_IDLE);
	assign st.done = emit && is_last;

	assign results.valid             = ovld_q;
	assign results.anomalous_tag     = otag_q;
	assign results.rank              = orank_q;
	assign results.capacity_exceeded = oovf_q;
	assign results.last_result       = olast_q;

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q[IDX_W-1:0];
		idx_s2  <= idx_s1;
		tag_s2  <= rd_s1[ENTRY_W-1:RATE_W];
		prod_s2 <= SUM_W'(prod_full);
		if (pop) begin
			n_q   <= head.n;
			sum_q <= head.sum;
			ovf_q <= head.ovf;
		end
		if (state_q == B_KMUL) begin
			kx_q <= T_W'(pct) * T_W'(n_q) + T_W'(K_ROUND);
		end
		if (state_q == B_KDIV) begin
			k_q <= k_new;
		end
		if (better) begin
			best_score_q <= score;
			best_idx_q   <= idx_s2;
			best_tag_q   <= tag_s2;
		end
		if (emit) begin
			otag_q  <= best_tag_q;
			orank_q <= RANK_W'(r_q);
			oovf_q  <= ovf_q;
			olast_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q   <= '0;
			r_q     <= '0;
			taken_q <= '0;
			found_q <= 1'b0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && !taken_q[idx_s1];
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (better) begin
				found_q <= 1'b1;
			end
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (results.ready) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						state_q <= B_KMUL;
					end
				end
				B_KMUL: begin
					state_q <= B_KDIV;
				end
				B_KDIV: begin
					idx_q   <= '0;
					r_q     <= '0;
					taken_q <= '0;
					found_q <= 1'b0;
					state_q <= B_SCAN;
				end
				B_SCAN: begin
					if (pass_end) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (emit) begin
						taken_q[best_idx_q] <= 1'b1;
						r_q     <= r_q + CNT_W'(1);
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= is_last ? B_IDLE : B_SCAN;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/zscore_top_k_outlier_select.sv =====
// Flow: a non-last item is absorbed on acceptance; after the last item of a set the back
//   computes k (B_KMUL, B_KDIV), then makes one scan over the loaded sources per result.
// Throughput: 1 item per cycle while loading; during selection, which takes one full
//   pass over the source store per emitted rank, input is held off.
// Reset: arst_n asynchronous, active low; clears counts, sum, overflow and control,
//   sets contamination_percent to 10. The source store keeps no reset.
module zscore_top_k_outlier_select (
	input  logic        clk,
	input  logic        arst_n,
	zotk_in_if.sink     items,
	zotk_out_if.source  results,
	zotk_cfg_if.sink    cfg
);
	import zotk_pkg::*;

	// configuration register, always ready; write it only while no set is in flight
	logic [PCT_W-1:0] pct_q;

	// front -> queue -> back
	wr_t  wr;
	job_t job;
	job_t head;
	logic job_push;
	logic q_pop;
	logic q_empty;
	logic q_full;
	logic fe_busy;
	bst_t bst;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= PCT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			pct_q <= cfg.contamination_percent;
		end
	end

	// Front: take transactions, write the store, keep count and sum, and
	// hand a closed set to the queue on the last item.
	zotk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.done     (bst.done),
		.wr       (wr),
		.job      (job),
		.job_push (job_push),
		.busy     (fe_busy)
	);

	// Queue of closed sets between front and back.
	zotk_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: compute k, then per rank one scan over the store picking the
	// largest |n*rate - sum| not taken yet (earliest wins ties), and emit it.
	zotk_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.head    (head),
		.empty   (q_empty),
		.pop     (q_pop),
		.pct     (pct_q),
		.results (results),
		.st      (bst)
	);

`ifndef SYNTH
	a_no_q_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_full)
		else $error("set queue overflow");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> (bst.idle && q_empty))
		else $error("input ready while a set is pending");

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bst.done |-> fe_busy)
		else $error("selection finished with no set pending");
`endif

endmodule

// ===== tb/sv/zscore_top_k_outlier_select_tb.sv =====
module zscore_top_k_outlier_select_tb;
	import zotk_pkg::*;

	// Run limits in clock cycles. The slowest legal run stays far below RUN_LIMIT:
	// one full-store set ranking every entry, a long receiver hold, and sender gaps.
	localparam int RUN_LIMIT  = 300000;
	localparam int LONG_HOLD  = 400;
	localparam int SETTLE     = 16;
	localparam int END_SETTLE = 100;

	typedef enum int {RATES_WIDE, RATES_NARROW, RATES_TOP, RATES_SPIKE} rate_mix_e;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [RATE_W-1:0] rate;
		logic              is_last;
	} src_item_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
		logic              over;
		logic              is_last;
	} outlier_t;

	logic clk;
	logic arst_n;

	zotk_in_if  items_ch ();
	zotk_out_if results_ch ();
	zotk_cfg_if cfg_ch ();

	zscore_top_k_outlier_select dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch.sink),
		.results (results_ch.source),
		.cfg     (cfg_ch.sink)
	);

	// Stimulus waiting to be offered, and outliers the block still owes us.
	src_item_t rates_to_send[$];
	outlier_t  pending_outliers[$];

	// Shadow of the block: the sources loaded in the open set and the setting.
	logic [RATE_W-1:0] seen_rate [MAX_SOURCES];
	logic [TAG_W-1:0]  seen_tag  [MAX_SOURCES];
	int                seen_count = 0;
	logic [SUM_W-1:0]  seen_sum = '0;
	logic              seen_dropped = 1'b0;
	logic [PCT_W-1:0]  pct_now = PCT_RESET;

	int items_queued  = 0;
	int items_taken   = 0;
	int results_seen  = 0;
	int sets_closed   = 0;
	int overflow_sets = 0;
	int errors        = 0;
	int cycle_count   = 0;

	int  tx_wait = 0;
	int  rx_wait = 0;
	int  hold_left = 0;
	logic hold_start = 1'b0;
	bit  gaps_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch in %s: got 0x%0h, want 0x%0h (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	// Mostly back to back, often a short gap, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Load one source into the shadow store; on the closing item rank the set by
	// |n * rate - sum| and queue the top k tags, earlier load winning a tie.
	task automatic load_and_rank(input src_item_t item);
		logic [63:0]            scaled;
		logic [63:0]            score;
		logic [63:0]            best_score;
		logic [MAX_SOURCES-1:0] taken;
		outlier_t               pick;
		int                     k;
		int                     best;
		bit                     found;
		if (seen_count < MAX_SOURCES) begin
			seen_rate[seen_count] = item.rate;
			seen_tag[seen_count]  = item.tag;
			seen_count++;
			seen_sum += item.rate;
		end else begin
			seen_dropped = 1'b1;
		end
		if (!item.is_last)
			return;

		// k = round half up of pct * n / 100, at least one, never more than n
		k = (int'(pct_now) * seen_count + 50) / 100;
		if (k < 1)
			k = 1;
		if (k > seen_count)
			k = seen_count;

		taken = '0;
		for (int r = 0; r < k; r++) begin
			found = 1'b0;
			best = 0;
			best_score = '0;
			for (int i = 0; i < seen_count; i++) begin
				if (taken[i])
					continue;
				scaled = 64'(seen_count) * 64'(seen_rate[i]);
				score = (scaled >= 64'(seen_sum)) ? scaled - 64'(seen_sum)
					: 64'(seen_sum) - scaled;
				if (!found || score > best_score) begin
					found = 1'b1;
					best = i;
					best_score = score;
				end
			end
			taken[best] = 1'b1;
			pick.tag     = seen_tag[best];
			pick.rank    = RANK_W'(r);
			pick.over    = seen_dropped;
			pick.is_last = (r + 1 == k);
			pending_outliers = {pending_outliers, pick};
		end

		if (seen_dropped)
			overflow_sets++;
		sets_closed++;
		seen_count = 0;
		seen_sum = '0;
		seen_dropped = 1'b0;
	endtask

	task automatic queue_item(input logic [TAG_W-1:0] tag, input logic [RATE_W-1:0] rate,
		input logic is_last);
		src_item_t item;
		item.tag     = tag;
		item.rate    = rate;
		item.is_last = is_last;
		rates_to_send = {rates_to_send, item};
		items_queued++;
	endtask

	// Queue one complete set; the last item of it closes the set.
	task automatic queue_set(input int count, input rate_mix_e mix);
		logic [RATE_W-1:0] base;
		logic [RATE_W-1:0] rate;
		logic [TAG_W-1:0]  tag;
		base = $urandom;
		for (int i = 0; i < count; i++) begin
			tag = TAG_W'($urandom);
			case (mix)
				RATES_WIDE: rate = $urandom;
				RATES_NARROW: begin
					// tiny spread: ties everywhere, and repeated tags
					rate = $urandom_range(0, 3);
					tag  = TAG_W'($urandom_range(0, 3));
				end
				RATES_TOP: rate = 32'hFFFF_FFFF - $urandom_range(0, 7);
				default: rate = ($urandom_range(0, 4) == 0) ? $urandom : base;
			endcase
			queue_item(tag, rate, i == count - 1);
		end
	endtask

	// Write the percent register; called only while the block is idle.
	task automatic write_percent(input logic [PCT_W-1:0] value);
		cfg_ch.contamination_percent <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold until every queued item went in and every owed outlier came out,
	// then let the selection pass wind down.
	task automatic drain();
		do @(posedge clk); while (items_taken != items_queued || pending_outliers.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Sender: offer the next queued item once the current one is taken and the gap
	// has run out. Valid stays high across back-to-back transactions.
	always @(posedge clk) begin
		src_item_t nxt;
		if (arst_n) begin
			if (!items_ch.valid || items_ch.ready) begin
				if (tx_wait != 0) begin
					items_ch.valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (rates_to_send.size() != 0) begin
					nxt = rates_to_send.pop_front();
					items_ch.source_tag <= nxt.tag;
					items_ch.rate       <= nxt.rate;
					items_ch.last_item  <= nxt.is_last;
					items_ch.valid      <= 1'b1;
					tx_wait <= pick_gap();
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted on its own so the block backs up into its input.
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Monitor: track config and input transactions in the shadow, check each
	// result transaction against the oldest owed outlier, and drive ready.
	always @(posedge clk) begin
		outlier_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				pct_now = cfg_ch.contamination_percent;

			if (items_ch.valid && items_ch.ready) begin
				want = '0;
				load_and_rank({items_ch.source_tag, items_ch.rate, items_ch.last_item});
				items_taken <= items_taken + 1;
			end

			if (results_ch.valid && results_ch.ready) begin
				if (pending_outliers.size() == 0) begin
					report_mismatch("result with nothing owed, tag", results_ch.anomalous_tag, 0);
				end else begin
					want = pending_outliers.pop_front();
					if (results_ch.anomalous_tag !== want.tag)
						report_mismatch("anomalous_tag", results_ch.anomalous_tag, want.tag);
					if (results_ch.rank !== want.rank)
						report_mismatch("rank", results_ch.rank, want.rank);
					if (results_ch.capacity_exceeded !== want.over)
						report_mismatch("capacity_exceeded", results_ch.capacity_exceeded,
							want.over);
					if (results_ch.last_result !== want.is_last)
						report_mismatch("last_result", results_ch.last_result, want.is_last);
				end
				results_seen <= results_seen + 1;
			end

			if (hold_left != 0) begin
				results_ch.ready <= 1'b0;
			end else if (rx_wait != 0) begin
				results_ch.ready <= 1'b0;
				rx_wait <= rx_wait - 1;
			end else begin
				results_ch.ready <= 1'b1;
				rx_wait <= pick_gap();
			end
		end
	end

	// Watchdog: give up on a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAIL zscore_top_k_outlier_select");
			$finish;
		end
	end

	initial begin
		logic [PCT_W-1:0] pct;
		int               phase_items;
		int               size;

		// Known values on every input from time zero; reset is asserted once at the start.
		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.source_tag = '0;
		items_ch.rate = '0;
		items_ch.last_item = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.contamination_percent = '0;
		results_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets at the reset percent of 10: field extremes with k rounding to
		// zero and raised to one, an exact tie between two sources, a lone source.
		queue_item(16'h0000, 32'h0000_0000, 1'b0);
		queue_item(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		queue_item(16'h5A5A, 32'h0000_0007, 1'b0);
		queue_item(16'hA5A5, 32'h0000_0001, 1'b1);
		queue_item(16'h0011, 32'd10, 1'b0);
		queue_item(16'h0022, 32'd20, 1'b1);
		queue_item(16'h0033, 32'hFFFF_FFFF, 1'b1);
		drain();

		// Every source reported; repeated tags come out once per load.
		write_percent(PCT_W'(100));
		queue_item(16'h0044, 32'd5, 1'b0);
		queue_item(16'h0044, 32'd5, 1'b0);
		queue_item(16'h0044, 32'd1000, 1'b0);
		queue_item(16'h7777, 32'd0, 1'b0);
		queue_item(16'h0044, 32'hFFFF_FFFF, 1'b1);
		drain();

		// Percent above 100 clipped to n; all scores equal, so load order decides.
		write_percent(PCT_W'(127));
		queue_item(16'h0101, 32'h8000_0000, 1'b0);
		queue_item(16'h0202, 32'h8000_0000, 1'b0);
		queue_item(16'h0303, 32'h8000_0000, 1'b1);
		drain();

		// Zero percent still reports one source.
		write_percent(PCT_W'(0));
		queue_item(16'h1000, 32'd3, 1'b0);
		queue_item(16'h2000, 32'd9, 1'b0);
		queue_item(16'h3000, 32'hDEAD_BEEF, 1'b0);
		queue_item(16'h4000, 32'd4, 1'b1);
		drain();

		// Random phases, one setting each. Phase 1 overfills the store at 100 percent
		// so all 64 ranks come out flagged; phase 3 holds the receiver off for a long
		// stretch while the sender keeps offering; phases 2 and 6 run with no gaps.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: pct = PCT_W'(50);
				1: pct = PCT_W'(100);
				2: pct = PCT_W'(1);
				3: pct = PCT_W'(127);
				4, 5: pct = PCT_W'($urandom_range(0, 127));
				6: pct = PCT_W'(99);
				default: pct = PCT_RESET;
			endcase
			write_percent(pct);
			gaps_on = (p != 2 && p != 6);
			if (p == 3) begin
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			if (p == 1)
				queue_set($urandom_range(MAX_SOURCES + 1, MAX_SOURCES + 3), RATES_WIDE);
			phase_items = 0;
			while (phase_items < 8) begin
				size = $urandom_range(1, 8);
				queue_set(size, rate_mix_e'($urandom_range(0, 3)));
				phase_items += size;
			end
			drain();
		end

		// Catch anything the block sends after the last owed outlier.
		repeat (END_SETTLE) @(posedge clk);
		if (pending_outliers.size() != 0)
			report_mismatch("outliers still owed", 0, pending_outliers.size());

		$display("run covered %0d source transactions in %0d sets (%0d over capacity),",
			items_taken, sets_closed, overflow_sets);
		$display("checked %0d ranked outliers across percent settings from 0 to 127", results_seen);
		if (errors == 0) begin
			$display("PASS zscore_top_k_outlier_select");
		end else begin
			$display("FAIL zscore_top_k_outlier_select");
		end
		$finish;
	end

endmodule
